>>> sv/accm_pkg.sv
// Package for the AES-128 CCM block engine: types, codes and AES helper functions.
`default_nettype none
package accm_pkg;

    localparam int BLK_BITS = 128;

    // Configuration register indexes.
    localparam logic [3:0] REG_KEY_LOW     = 4'd0;
    localparam logic [3:0] REG_KEY_HIGH    = 4'd1;
    localparam logic [3:0] REG_NONCE_LOW   = 4'd2;
    localparam logic [3:0] REG_NONCE_HIGH  = 4'd3;
    localparam logic [3:0] REG_TAG_LENGTH  = 4'd4;
    localparam logic [3:0] REG_PAYLOAD_LEN = 4'd5;
    localparam logic [3:0] REG_ASSOC       = 4'd6;
    localparam logic [3:0] REG_DECRYPT     = 4'd7;

    localparam logic [7:0] CTR_FLAGS  = 8'd2;
    localparam logic [7:0] ASSOC_FLAG = 8'h40;
    localparam logic [23:0] LEN_ROUND = 24'd15;
    localparam logic [4:0] BLK_BYTES  = 5'd16;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    // Datapath operations.
    localparam logic [3:0] DP_NOP     = 4'd0;
    localparam logic [3:0] DP_CAPTURE = 4'd1;
    localparam logic [3:0] DP_START   = 4'd2;
    localparam logic [3:0] DP_LD_MAC  = 4'd3;
    localparam logic [3:0] DP_LD_CTR  = 4'd4;
    localparam logic [3:0] DP_ROUND   = 4'd5;
    localparam logic [3:0] DP_ST_B0   = 4'd6;
    localparam logic [3:0] DP_ST_S0   = 4'd7;
    localparam logic [3:0] DP_ST_KS   = 4'd8;
    localparam logic [3:0] DP_FIN     = 4'd9;

    typedef struct packed {
        logic [3:0] op;
        logic       final_round;
    } cmd_t;

    typedef struct packed {
        logic in_last;
    } status_t;

    localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xt(input logic [7:0] b);
        xt = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the result is byte 15-i of the argument.
    function automatic logic [127:0] rev_bytes(input logic [127:0] x);
        for (int i = 0; i < 16; i++) begin
            rev_bytes[8*i +: 8] = x[8*(15-i) +: 8];
        end
    endfunction

    // One step of the AES-128 key schedule.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rc);
        logic [31:0] t;
        logic [31:0] w;
        t = {SBOX[k[103:96]], SBOX[k[127:120]], SBOX[k[119:112]], SBOX[k[111:104]] ^ rc};
        w = k[31:0] ^ t;
        key_step[31:0] = w;
        w = k[63:32] ^ w;
        key_step[63:32] = w;
        w = k[95:64] ^ w;
        key_step[95:64] = w;
        w = k[127:96] ^ w;
        key_step[127:96] = w;
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic final_round);
        logic [127:0] u;
        logic [7:0] a0, a1, a2, a3, t;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                u[8*(i+4*c) +: 8] = SBOX[s[8*(i+4*((c+i)%4)) +: 8]];
            end
        end
        if (!final_round) begin
            for (int c = 0; c < 4; c++) begin
                a0 = u[8*(4*c) +: 8];
                a1 = u[8*(4*c+1) +: 8];
                a2 = u[8*(4*c+2) +: 8];
                a3 = u[8*(4*c+3) +: 8];
                t = a0 ^ a1 ^ a2 ^ a3;
                u[8*(4*c) +: 8]   = a0 ^ t ^ xt(a0 ^ a1);
                u[8*(4*c+1) +: 8] = a1 ^ t ^ xt(a1 ^ a2);
                u[8*(4*c+2) +: 8] = a2 ^ t ^ xt(a2 ^ a3);
                u[8*(4*c+3) +: 8] = a3 ^ t ^ xt(a3 ^ a0);
            end
        end
        aes_round = u ^ rk;
    endfunction

endpackage
`default_nettype wire

>>> sv/accm_ctrl.sv
// Controller state machine of the AES-128 CCM block engine.
`default_nettype none
module accm_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire accm_pkg::status_t status,
    output accm_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_LD_B0  = 4'd2;
    localparam logic [3:0] S_ST_B0  = 4'd3;
    localparam logic [3:0] S_LD_S0  = 4'd4;
    localparam logic [3:0] S_ST_S0  = 4'd5;
    localparam logic [3:0] S_LD_KS  = 4'd6;
    localparam logic [3:0] S_ST_KS  = 4'd7;
    localparam logic [3:0] S_LD_MAC = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;
    localparam logic [3:0] S_ROUND  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       in_msg_reg, in_msg_next;
    logic       mv_reg, mv_next;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        rnd_next    = rnd_reg;
        in_msg_next = in_msg_reg;
        mv_next     = mv_reg && !m_tready;
        cmd.op          = accm_pkg::DP_NOP;
        cmd.final_round = (rnd_reg == accm_pkg::LAST_ROUND);
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = accm_pkg::DP_CAPTURE;
                    state_next = in_msg_reg ? S_LD_KS : S_START;
                end
            end
            S_START: begin
                cmd.op     = accm_pkg::DP_START;
                state_next = S_LD_B0;
            end
            S_LD_B0: begin
                cmd.op     = accm_pkg::DP_LD_MAC;
                rnd_next   = 4'd1;
                ret_next   = S_ST_B0;
                state_next = S_ROUND;
            end
            S_ST_B0: begin
                cmd.op     = accm_pkg::DP_ST_B0;
                state_next = S_LD_S0;
            end
            S_LD_S0: begin
                cmd.op     = accm_pkg::DP_LD_CTR;
                rnd_next   = 4'd1;
                ret_next   = S_ST_S0;
                state_next = S_ROUND;
            end
            S_ST_S0: begin
                cmd.op      = accm_pkg::DP_ST_S0;
                in_msg_next = 1'b1;
                state_next  = S_LD_KS;
            end
            S_LD_KS: begin
                cmd.op     = accm_pkg::DP_LD_CTR;
                rnd_next   = 4'd1;
                ret_next   = S_ST_KS;
                state_next = S_ROUND;
            end
            S_ST_KS: begin
                cmd.op     = accm_pkg::DP_ST_KS;
                state_next = S_LD_MAC;
            end
            S_LD_MAC: begin
                cmd.op     = accm_pkg::DP_LD_MAC;
                rnd_next   = 4'd1;
                ret_next   = S_FIN;
                state_next = S_ROUND;
            end
            S_FIN: begin
                if (!mv_reg || m_tready) begin
                    cmd.op      = accm_pkg::DP_FIN;
                    mv_next     = 1'b1;
                    in_msg_next = !status.in_last;
                    state_next  = S_IDLE;
                end
            end
            S_ROUND: begin
                cmd.op   = accm_pkg::DP_ROUND;
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == accm_pkg::LAST_ROUND) begin
                    state_next = ret_reg;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_IDLE;
            rnd_reg    <= 4'd0;
            in_msg_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            rnd_reg    <= rnd_next;
            in_msg_reg <= in_msg_next;
            mv_reg     <= mv_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/accm_datapath.sv
// Datapath of the AES-128 CCM block engine: config registers, AES round unit, CCM state.
`default_nettype none
module accm_datapath (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    input  wire logic [3:0]      cfg_index,
    input  wire logic [63:0]     cfg_data,
    input  wire logic [135:0]    s_tdata,
    input  wire logic            s_tlast,
    output logic [255:0]         m_tdata,
    output logic                 m_tlast,
    input  wire accm_pkg::cmd_t  cmd,
    output accm_pkg::status_t    status
);

    logic [63:0] key_low_reg, key_high_reg, nonce_low_reg;
    logic [31:0] nonce_high_reg;
    logic [4:0]  tag_len_reg;
    logic [23:0] plen_reg;
    logic        assoc_reg, dec_reg;

    logic [127:0] key0_reg, rk_reg, st_reg, mac_reg, ctr_reg, mask_reg;
    logic [7:0]   rc_reg;
    logic [127:0] din_reg;
    logic [4:0]   cnt_reg;
    logic         last_reg;
    logic [127:0] ob_reg;
    logic [127:0] out_reg, tag_reg;
    logic         olast_reg;

    logic [127:0] key0_next, b0_next, ctr0_next, ld_src, ctr_inc;
    logic [127:0] kr, pt, ob;
    logic [23:0]  plen_rnd;
    logic [2:0]   mfield;
    logic [4:0]   tl_m2, n_eff;

    assign status.in_last = last_reg;
    assign m_tdata = {tag_reg, out_reg};
    assign m_tlast = olast_reg;

    always_comb begin
        key0_next = accm_pkg::rev_bytes({key_high_reg, key_low_reg});
        plen_rnd  = (plen_reg + accm_pkg::LEN_ROUND) & ~accm_pkg::LEN_ROUND;
        tl_m2     = tag_len_reg - 5'd2;
        mfield    = tl_m2[3:1];
        b0_next[7:0] = {2'b00, mfield, 3'b000} | accm_pkg::CTR_FLAGS
                       | (assoc_reg ? accm_pkg::ASSOC_FLAG : 8'h00);
        ctr0_next[7:0] = accm_pkg::CTR_FLAGS;
        for (int i = 0; i < 12; i++) begin
            if (11 - i < 8) begin
                b0_next[8*(1+i) +: 8] = nonce_low_reg[8*(11-i) +: 8];
            end else begin
                b0_next[8*(1+i) +: 8] = nonce_high_reg[8*(3-i) +: 8];
            end
            ctr0_next[8*(1+i) +: 8] = b0_next[8*(1+i) +: 8];
        end
        b0_next[127:104]   = {plen_rnd[7:0], plen_rnd[15:8], plen_rnd[23:16]};
        ctr0_next[127:104] = 24'd0;

        ld_src  = (cmd.op == accm_pkg::DP_LD_MAC) ? mac_reg : ctr_reg;
        ctr_inc = accm_pkg::rev_bytes(accm_pkg::rev_bytes(ctr_reg) + 128'd1);

        n_eff = !last_reg ? accm_pkg::BLK_BYTES
              : ((cnt_reg > accm_pkg::BLK_BYTES) ? accm_pkg::BLK_BYTES : cnt_reg);
        kr = accm_pkg::rev_bytes(st_reg);
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < n_eff) begin
                pt[8*i +: 8] = dec_reg ? (din_reg[8*i +: 8] ^ kr[8*i +: 8]) : din_reg[8*i +: 8];
                ob[8*i +: 8] = din_reg[8*i +: 8] ^ kr[8*i +: 8];
            end else begin
                pt[8*i +: 8] = 8'h00;
                ob[8*i +: 8] = 8'h00;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            tag_len_reg    <= accm_pkg::BLK_BYTES;
            plen_reg       <= '0;
            assoc_reg      <= 1'b0;
            dec_reg        <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                accm_pkg::REG_KEY_LOW:     key_low_reg    <= cfg_data;
                accm_pkg::REG_KEY_HIGH:    key_high_reg   <= cfg_data;
                accm_pkg::REG_NONCE_LOW:   nonce_low_reg  <= cfg_data;
                accm_pkg::REG_NONCE_HIGH:  nonce_high_reg <= cfg_data[31:0];
                accm_pkg::REG_TAG_LENGTH:  tag_len_reg    <= cfg_data[4:0];
                accm_pkg::REG_PAYLOAD_LEN: plen_reg       <= cfg_data[23:0];
                accm_pkg::REG_ASSOC:       assoc_reg      <= cfg_data[0];
                accm_pkg::REG_DECRYPT:     dec_reg        <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg  <= '0;
            ctr_reg  <= '0;
            mask_reg <= '0;
        end else begin
            case (cmd.op)
                accm_pkg::DP_START: begin
                    mac_reg <= b0_next;
                    ctr_reg <= ctr0_next;
                end
                accm_pkg::DP_ST_B0: mac_reg <= st_reg;
                accm_pkg::DP_ST_S0: begin
                    mask_reg <= accm_pkg::rev_bytes(st_reg);
                    ctr_reg  <= ctr_inc;
                end
                accm_pkg::DP_ST_KS: begin
                    mac_reg <= mac_reg ^ accm_pkg::rev_bytes(pt);
                    ctr_reg <= ctr_inc;
                end
                accm_pkg::DP_FIN: mac_reg <= st_reg;
                default: ;
            endcase
        end
    end

    // The processed bytes wait in ob_reg so that a result still on the output
    // keeps its data until the new one is published together with its tag.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            accm_pkg::DP_CAPTURE: begin
                din_reg  <= s_tdata[127:0];
                cnt_reg  <= s_tdata[132:128];
                last_reg <= s_tlast;
            end
            accm_pkg::DP_START: key0_reg <= key0_next;
            accm_pkg::DP_LD_MAC, accm_pkg::DP_LD_CTR: begin
                st_reg <= ld_src ^ key0_reg;
                rk_reg <= accm_pkg::key_step(key0_reg, 8'h01);
                rc_reg <= 8'h02;
            end
            accm_pkg::DP_ROUND: begin
                st_reg <= accm_pkg::aes_round(st_reg, rk_reg, cmd.final_round);
                rk_reg <= accm_pkg::key_step(rk_reg, rc_reg);
                rc_reg <= accm_pkg::xt(rc_reg);
            end
            accm_pkg::DP_ST_KS: ob_reg <= ob;
            accm_pkg::DP_FIN: begin
                out_reg   <= ob_reg;
                tag_reg   <= accm_pkg::rev_bytes(st_reg) ^ mask_reg;
                olast_reg <= last_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/aes_ccm_block_engine.sv
// Top level of the AES-128 CCM block engine.
// A block that continues a message is encrypted for its keystream and its MAC before its result;
// for the first block of a message, B0 and S0 are encrypted first.
// Blocks are taken one at a time, only when idle; one iterative AES round unit runs the keystream
// encryption and then the MAC encryption, ten rounds each, with the key schedule on the fly.
// Reset: aresetn is synchronous and active low; it clears the configuration registers, the chain and state.
`default_nettype none
module aes_ccm_block_engine (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Configuration write channel: an index and data move in one transfer.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    // Input blocks.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [135:0] s_tdata,   // data_low[63:0], data_high[127:64], byte_count[132:128]
    input  wire logic         s_tlast,   // last
    // Results.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [255:0]      m_tdata,   // out_low, out_high, tag_low, tag_high
    output logic              m_tlast    // out_last
);

    accm_pkg::cmd_t    cmd;
    accm_pkg::status_t status;

    // Configuration writes always pass unchecked; the user must issue them only while the engine is idle.
    assign cfg_ready = 1'b1;

    // The controller sequences the loads and rounds; the datapath holds all block state.
    accm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    accm_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    // After an input transfer the engine is busy with that block.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a transfer");

    // A new result appears only at the end of block processing.
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result raised while the engine was idle");

endmodule
`default_nettype wire
